@@ src/escaped_frame_receiver_core_defines.svh @@
// Assertion helpers shared by the frame receiver.
`ifndef ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/efr_pkg.sv @@
`timescale 1ns / 1ps

package efr_pkg;

   // Result kinds as they appear on the result channel.
   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_CSUM_ERR = 2'd2,
      KIND_LEN_ERR  = 2'd3
   } efr_kind_type;

   // Register indexes on the configuration port.
   localparam logic [1:0] CSR_START_BYTE  = 2'd0;
   localparam logic [1:0] CSR_END_BYTE    = 2'd1;
   localparam logic [1:0] CSR_ESCAPE_BYTE = 2'd2;
   localparam logic [1:0] CSR_MAX_PAYLOAD = 2'd3;

   // Register reset values.
   localparam logic [7:0]  START_BYTE_RESET  = 8'd126;
   localparam logic [7:0]  END_BYTE_RESET    = 8'd127;
   localparam logic [7:0]  ESCAPE_BYTE_RESET = 8'd125;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

   // Depth of the token queue between the front and the back.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [7:0]  escape_byte;
      logic [15:0] max_payload;
   } efr_cfg_type;

   // A decoded byte: unescaped start or end marks plus the literal value.
   typedef struct packed {
      logic       is_start;
      logic       is_end;
      logic [7:0] data;
   } efr_token_type;

   typedef struct packed {
      logic empty;
      logic full;
   } efr_qstat_type;

endpackage

@@ src/efr_front.sv @@
`timescale 1ns / 1ps

module efr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  efr_pkg::efr_cfg_type cfg,
   input  efr_pkg::efr_qstat_type qstat,
   output logic                 push,
   output efr_pkg::efr_token_type token
);
   import efr_pkg::*;

   logic escape_pending_ff;
   logic escape_pending_in;
   logic accept;

   // The front holds off the sender only while the queue is full.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   // Escape removal and marker classification.
   always_comb begin
      escape_pending_in = escape_pending_ff;
      push              = 1'b0;
      token.data        = req_rx_byte;
      token.is_start    = 1'b0;
      token.is_end      = 1'b0;
      if (accept) begin
         if (escape_pending_ff) begin
            escape_pending_in = 1'b0;
            push              = 1'b1;
         end else if (req_rx_byte == cfg.escape_byte) begin
            escape_pending_in = 1'b1;
         end else begin
            push           = 1'b1;
            token.is_start = (req_rx_byte == cfg.start_byte);
            token.is_end   = (req_rx_byte == cfg.end_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_pending_ff <= 1'b0;
      end else begin
         escape_pending_ff <= escape_pending_in;
      end
   end

endmodule

@@ src/efr_queue.sv @@
`timescale 1ns / 1ps

module efr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  efr_pkg::efr_token_type push_token,
   input  logic                  pop,
   output efr_pkg::efr_token_type head,
   output efr_pkg::efr_qstat_type qstat
);
   import efr_pkg::*;

   efr_token_type           entries [QDEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff;
   logic [QPTR_W-1:0]       rd_ptr_ff;
   logic [QPTR_W:0]         count_ff;

   assign head        = entries[rd_ptr_ff];
   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (QPTR_W+1)'(QDEPTH));

   // Token storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_token;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ src/efr_back.sv @@
`timescale 1ns / 1ps

module efr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  efr_pkg::efr_qstat_type qstat,
   input  efr_pkg::efr_token_type token,
   output logic                  pop,
   input  logic [15:0]           max_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_byte_value,
   output logic [15:0]           rsp_byte_index,
   output logic [7:0]            rsp_command,
   output logic [15:0]           rsp_length,
   output logic [7:0]            rsp_received_checksum,
   output logic [7:0]            rsp_computed_checksum,
   output logic [31:0]           rsp_good_frames,
   output logic [31:0]           rsp_checksum_errors,
   output logic [31:0]           rsp_length_errors
);
   import efr_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CMD,
      PH_LEN_HI,
      PH_LEN_LO,
      PH_DATA,
      PH_CHECKSUM,
      PH_WAIT_END
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   command_ff, command_in;
   logic [15:0]  length_ff, length_in;
   logic [15:0]  count_ff, count_in;
   logic [7:0]   xor_ff, xor_in;
   logic [7:0]   csum_ff, csum_in;
   logic [31:0]  good_ff, good_in;
   logic [31:0]  csum_err_ff, csum_err_in;
   logic [31:0]  len_err_ff, len_err_in;

   logic         rsp_valid_ff;
   efr_kind_type rsp_kind_ff;
   logic [7:0]   rsp_byte_value_ff;
   logic [15:0]  rsp_byte_index_ff;
   logic [7:0]   rsp_rx_sum_ff;

   logic         emit;
   efr_kind_type emit_kind;
   logic [7:0]   emit_value;
   logic [15:0]  emit_index;
   logic [7:0]   emit_rx_sum;
   logic [15:0]  low_length;

   // A queued token is taken whenever the result register is free or draining.
   assign pop        = !qstat.empty && (!rsp_valid_ff || !rsp_stall);
   assign low_length = {length_ff[15:8], token.data};

   // Frame parser: next state and the result it causes.
   always_comb begin
      phase_in    = phase_ff;
      command_in  = command_ff;
      length_in   = length_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      csum_in     = csum_ff;
      good_in     = good_ff;
      csum_err_in = csum_err_ff;
      len_err_in  = len_err_ff;
      emit        = 1'b0;
      emit_kind   = KIND_PAYLOAD;
      emit_value  = 8'h00;
      emit_index  = 16'h0000;
      emit_rx_sum = 8'h00;
      if (pop) begin
         if (token.is_start) begin
            phase_in   = PH_CMD;
            command_in = 8'h00;
            length_in  = 16'h0000;
            count_in   = 16'h0000;
            xor_in     = 8'h00;
            csum_in    = 8'h00;
         end else if (token.is_end && (phase_ff == PH_WAIT_END)) begin
            emit        = 1'b1;
            emit_rx_sum = csum_ff;
            phase_in    = PH_IDLE;
            if (xor_ff == csum_ff) begin
               good_in   = good_ff + 32'd1;
               emit_kind = KIND_GOOD;
            end else begin
               csum_err_in = csum_err_ff + 32'd1;
               emit_kind   = KIND_CSUM_ERR;
            end
         end else begin
            case (phase_ff)
               PH_CMD: begin
                  command_in = token.data;
                  xor_in     = xor_ff ^ token.data;
                  phase_in   = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  length_in = {token.data, 8'h00};
                  xor_in    = xor_ff ^ token.data;
                  phase_in  = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  length_in = low_length;
                  xor_in    = xor_ff ^ token.data;
                  if (low_length > max_payload) begin
                     len_err_in = len_err_ff + 32'd1;
                     emit       = 1'b1;
                     emit_kind  = KIND_LEN_ERR;
                     phase_in   = PH_IDLE;
                  end else begin
                     count_in = 16'h0000;
                     phase_in = (low_length != 16'h0000) ? PH_DATA : PH_CHECKSUM;
                  end
               end
               PH_DATA: begin
                  xor_in     = xor_ff ^ token.data;
                  count_in   = count_ff + 16'd1;
                  emit       = 1'b1;
                  emit_kind  = KIND_PAYLOAD;
                  emit_value = token.data;
                  emit_index = count_ff;
                  if (count_in >= length_ff) begin
                     phase_in = PH_CHECKSUM;
                  end
               end
               PH_CHECKSUM: begin
                  csum_in  = token.data;
                  phase_in = PH_WAIT_END;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Parser state and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         command_ff   <= 8'h00;
         length_ff    <= 16'h0000;
         count_ff     <= 16'h0000;
         xor_ff       <= 8'h00;
         csum_ff      <= 8'h00;
         good_ff      <= 32'h0;
         csum_err_ff  <= 32'h0;
         len_err_ff   <= 32'h0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         length_ff   <= length_in;
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         csum_ff     <= csum_in;
         good_ff     <= good_in;
         csum_err_ff <= csum_err_in;
         len_err_ff  <= len_err_in;
         if (pop && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (pop && emit) begin
         rsp_kind_ff       <= emit_kind;
         rsp_byte_value_ff <= emit_value;
         rsp_byte_index_ff <= emit_index;
         rsp_rx_sum_ff     <= emit_rx_sum;
      end
   end

   // Frame fields and counters follow the parser state, which holds
   // still while a result waits.
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = rsp_kind_ff;
   assign rsp_byte_value        = rsp_byte_value_ff;
   assign rsp_byte_index        = rsp_byte_index_ff;
   assign rsp_received_checksum = rsp_rx_sum_ff;
   assign rsp_command           = command_ff;
   assign rsp_length            = length_ff;
   assign rsp_computed_checksum = xor_ff;
   assign rsp_good_frames       = good_ff;
   assign rsp_checksum_errors   = csum_err_ff;
   assign rsp_length_errors     = len_err_ff;

endmodule

@@ src/escaped_frame_receiver_core.sv @@
`timescale 1ns / 1ps
// A result is registered: an accepted byte is written into the token queue, then
// the back part takes it from the queue head and registers the result it causes.
// Throughput: one byte per cycle while the queue is not full; the back parser takes
// one queued byte per cycle unless a result waits, and the two-entry queue decouples
// it from the receive side. Reset (synchronous, active high) clears the parser, the
// escape flag, queue, counters and result valid flag, and restores register defaults.
`include "escaped_frame_receiver_core_defines.svh"

module escaped_frame_receiver_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_byte_value,
   output logic [15:0] rsp_byte_index,
   output logic [7:0]  rsp_command,
   output logic [15:0] rsp_length,
   output logic [7:0]  rsp_received_checksum,
   output logic [7:0]  rsp_computed_checksum,
   output logic [31:0] rsp_good_frames,
   output logic [31:0] rsp_checksum_errors,
   output logic [31:0] rsp_length_errors,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import efr_pkg::*;

   efr_cfg_type   cfg_ff;
   efr_qstat_type qstat;
   efr_token_type push_token;
   efr_token_type head;
   logic          push;
   logic          pop;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte  <= START_BYTE_RESET;
         cfg_ff.end_byte    <= END_BYTE_RESET;
         cfg_ff.escape_byte <= ESCAPE_BYTE_RESET;
         cfg_ff.max_payload <= MAX_PAYLOAD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_BYTE:  cfg_ff.start_byte  <= csr_data[7:0];
            CSR_END_BYTE:    cfg_ff.end_byte    <= csr_data[7:0];
            CSR_ESCAPE_BYTE: cfg_ff.escape_byte <= csr_data[7:0];
            CSR_MAX_PAYLOAD: cfg_ff.max_payload <= csr_data;
            default: begin
            end
         endcase
      end
   end

   efr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .cfg         (cfg_ff),
      .qstat       (qstat),
      .push        (push),
      .token       (push_token)
   );

   efr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   efr_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .qstat                 (qstat),
      .token                 (head),
      .pop                   (pop),
      .max_payload           (cfg_ff.max_payload),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_kind              (rsp_kind),
      .rsp_byte_value        (rsp_byte_value),
      .rsp_byte_index        (rsp_byte_index),
      .rsp_command           (rsp_command),
      .rsp_length            (rsp_length),
      .rsp_received_checksum (rsp_received_checksum),
      .rsp_computed_checksum (rsp_computed_checksum),
      .rsp_good_frames       (rsp_good_frames),
      .rsp_checksum_errors   (rsp_checksum_errors),
      .rsp_length_errors     (rsp_length_errors)
   );

   // A good frame always carries a matching checksum.
   `EFR_ASSERT_NOW(a_good_matches, clock, reset, rsp_valid && (rsp_kind == KIND_GOOD), rsp_received_checksum == rsp_computed_checksum, "good frame with checksum mismatch")

   // A payload byte always lies inside the announced length.
   `EFR_ASSERT_NOW(a_index_in_range, clock, reset, rsp_valid && (rsp_kind == KIND_PAYLOAD), rsp_byte_index < rsp_length, "payload index beyond frame length")

   // A length abort only reports lengths above the limit.
   `EFR_ASSERT_NOW(a_len_err_oversize, clock, reset, rsp_valid && (rsp_kind == KIND_LEN_ERR), rsp_length > cfg_ff.max_payload, "length abort for an allowed length")

   // No token is pushed into a full queue without a pop in the same cycle.
   `EFR_ASSERT_NOW(a_no_overflow, clock, reset, push, !qstat.full || pop, "token queue overflow")

endmodule
